FILE: sv/fcsg_pkg.sv
// ----------------------------------------------------------------------------
// Filled circle span generator package
// Shared widths, limit constants, register indexes and span kind codes.
// ----------------------------------------------------------------------------
package fcsg_pkg;

    // Step index width, fixed by the request format
    localparam int STEP_W = 11;

    // Configuration port widths
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Octant limit: step passes when LIMIT_I_MUL * i <= LIMIT_R_MUL * radius
    localparam int LIMIT_I_MUL = 1414;
    localparam int LIMIT_R_MUL = 1000;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_CENTRE_X = 2'd0,
        REG_CENTRE_Y = 2'd1,
        REG_RADIUS   = 2'd2
    } reg_idx_t;

    // Span order within one step
    typedef enum logic [1:0] {
        SPAN_POS_J = 2'd0,   // row +j, half width i
        SPAN_POS_I = 2'd1,   // row +i, half width j
        SPAN_NEG_I = 2'd2,   // row -i, half width j
        SPAN_NEG_J = 2'd3    // row -j, half width i
    } span_kind_t;

endpackage

FILE: sv/fcsg_front.sv
// ----------------------------------------------------------------------------
// Filled circle span generator front end
// Limit test and squaring stage, then the radicand subtract stage.
// ----------------------------------------------------------------------------
module fcsg_front
    import fcsg_pkg::*;
#(
    parameter int COORD_WIDTH = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [COORD_WIDTH-2:0]      radius,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [STEP_W-1:0]           in_step,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [STEP_W-1:0]           out_step,
    output logic [2*(COORD_WIDTH-1)-1:0] out_rem
);

    localparam int RW    = COORD_WIDTH - 1;
    localparam int NW    = 2 * RW;
    localparam int SQ_W  = 2 * STEP_W;
    localparam int CMP_W = (RW + 10 > SQ_W) ? RW + 10 : SQ_W;

    logic [CMP_W-1:0] lim_i;
    logic [CMP_W-1:0] lim_r;
    logic             pass;
    logic [SQ_W-1:0]  isq;

    logic              a_valid_reg;
    logic [STEP_W-1:0] a_step_reg;
    logic [NW-1:0]     a_rsq_reg;
    logic [NW-1:0]     a_isq_reg;
    logic              a_ready;

    logic              b_valid_reg;
    logic [STEP_W-1:0] b_step_reg;
    logic [NW-1:0]     b_rem_reg;
    logic              b_ready;

    // Stage A: limit test and both squares
    assign lim_i    = CMP_W'(in_step) * CMP_W'(LIMIT_I_MUL);
    assign lim_r    = CMP_W'(radius) * CMP_W'(LIMIT_R_MUL);
    assign pass     = (lim_i <= lim_r);
    assign isq      = SQ_W'(in_step) * SQ_W'(in_step);
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            // drop steps beyond the octant limit
            a_valid_reg <= in_valid && pass;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_step_reg <= in_step;
            a_rsq_reg  <= NW'(radius) * NW'(radius);
            a_isq_reg  <= NW'(isq);
        end
    end

    // Stage B: radicand r*r - i*i (i <= r on every passing step)
    assign b_ready = !b_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_step_reg <= a_step_reg;
            b_rem_reg  <= a_rsq_reg - a_isq_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_step  = b_step_reg;
    assign out_rem   = b_rem_reg;

endmodule

FILE: sv/fcsg_sqrt.sv
// ----------------------------------------------------------------------------
// Filled circle span generator square root pipeline
// Digit-by-digit integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module fcsg_sqrt
    import fcsg_pkg::*;
#(
    parameter int COORD_WIDTH = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [STEP_W-1:0]            in_step,
    input  logic [2*(COORD_WIDTH-1)-1:0] in_rem,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [STEP_W-1:0]            out_step,
    output logic [COORD_WIDTH-2:0]       out_root
);

    localparam int RW = COORD_WIDTH - 1;
    localparam int NW = 2 * RW;

    logic              valid_reg [RW];
    logic [STEP_W-1:0] step_reg  [RW];
    logic [NW-1:0]     rem_reg   [RW];
    logic [RW-1:0]     root_reg  [RW];
    logic              stg_ready [RW];

    logic              src_valid [RW];
    logic [STEP_W-1:0] src_step  [RW];
    logic [NW-1:0]     src_rem   [RW];
    logic [RW-1:0]     src_root  [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stage
        localparam int K = RW - 1 - s;

        logic [NW:0]   trial;
        logic          take;
        logic [NW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (s == 0) begin : g_first
            assign src_valid[s] = in_valid;
            assign src_step[s]  = in_step;
            assign src_rem[s]   = in_rem;
            assign src_root[s]  = '0;
        end else begin : g_next
            assign src_valid[s] = valid_reg[s-1];
            assign src_step[s]  = step_reg[s-1];
            assign src_rem[s]   = rem_reg[s-1];
            assign src_root[s]  = root_reg[s-1];
        end

        if (s == RW - 1) begin : g_last_rdy
            assign stg_ready[s] = !valid_reg[s] || out_ready;
        end else begin : g_mid_rdy
            assign stg_ready[s] = !valid_reg[s] || stg_ready[s+1];
        end

        // try setting bit K of the root against the remaining radicand
        assign trial     = ((NW+1)'(src_root[s]) << (K + 1)) + ((NW+1)'(1) << (2 * K));
        assign take      = ({1'b0, src_rem[s]} >= trial);
        assign rem_next  = take ? (src_rem[s] - NW'(trial)) : src_rem[s];
        assign root_next = take ? (src_root[s] | (RW'(1) << K)) : src_root[s];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (stg_ready[s]) begin
                valid_reg[s] <= src_valid[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (stg_ready[s] && src_valid[s]) begin
                step_reg[s] <= src_step[s];
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign in_ready  = stg_ready[0];
    assign out_valid = valid_reg[RW-1];
    assign out_step  = step_reg[RW-1];
    assign out_root  = root_reg[RW-1];

endmodule

FILE: sv/fcsg_span.sv
// ----------------------------------------------------------------------------
// Filled circle span generator span sequencer
// Holds one step and emits its four spans through an output register.
// ----------------------------------------------------------------------------
module fcsg_span
    import fcsg_pkg::*;
#(
    parameter int COORD_WIDTH = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic signed [COORD_WIDTH-1:0] centre_x,
    input  logic signed [COORD_WIDTH-1:0] centre_y,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [STEP_W-1:0]             in_step,
    input  logic [COORD_WIDTH-2:0]        in_root,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH:0]   m_span_row,
    output logic signed [COORD_WIDTH:0]   m_span_left,
    output logic signed [COORD_WIDTH:0]   m_span_right,
    output span_kind_t                    m_span_kind,
    output logic                          m_last_span
);

    localparam int RW = COORD_WIDTH - 1;
    localparam int OW = COORD_WIDTH + 1;

    logic          hold_valid_reg;
    span_kind_t    hold_kind_reg;
    logic [RW-1:0] hold_i_reg;
    logic [RW-1:0] hold_j_reg;

    logic          load;
    logic          done;

    logic [RW-1:0] row_mag;
    logic [RW-1:0] half;
    logic          row_neg;

    logic signed [OW-1:0] cx_ext;
    logic signed [OW-1:0] cy_ext;
    logic signed [OW-1:0] mag_ext;
    logic signed [OW-1:0] half_ext;
    logic signed [OW-1:0] row_next;
    logic signed [OW-1:0] left_next;
    logic signed [OW-1:0] right_next;

    logic                 m_valid_reg;
    logic signed [OW-1:0] m_row_reg;
    logic signed [OW-1:0] m_left_reg;
    logic signed [OW-1:0] m_right_reg;
    span_kind_t           m_kind_reg;
    logic                 m_last_reg;

    assign load     = hold_valid_reg && (!m_valid_reg || m_ready);
    assign done     = load && (hold_kind_reg == SPAN_NEG_J);
    assign in_ready = !hold_valid_reg || done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            hold_kind_reg  <= SPAN_POS_J;
        end else if (in_valid && in_ready) begin
            hold_valid_reg <= 1'b1;
            hold_kind_reg  <= SPAN_POS_J;
        end else if (done) begin
            hold_valid_reg <= 1'b0;
        end else if (load) begin
            hold_kind_reg <= span_kind_t'(hold_kind_reg + 2'd1);
        end
    end

    // i never exceeds the radius on a passing step, so it fits the root width
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            hold_i_reg <= RW'(in_step);
            hold_j_reg <= in_root;
        end
    end

    always_comb begin
        row_mag = '0;
        half    = '0;
        row_neg = 1'b0;
        case (hold_kind_reg)
            SPAN_POS_J: begin
                row_mag = hold_j_reg;
                half    = hold_i_reg;
            end
            SPAN_POS_I: begin
                row_mag = hold_i_reg;
                half    = hold_j_reg;
            end
            SPAN_NEG_I: begin
                row_mag = hold_i_reg;
                half    = hold_j_reg;
                row_neg = 1'b1;
            end
            SPAN_NEG_J: begin
                row_mag = hold_j_reg;
                half    = hold_i_reg;
                row_neg = 1'b1;
            end
            default: begin
                row_mag = '0;
                half    = '0;
            end
        endcase
    end

    assign cx_ext     = OW'(centre_x);
    assign cy_ext     = OW'(centre_y);
    assign mag_ext    = signed'(OW'(row_mag));
    assign half_ext   = signed'(OW'(half));
    assign row_next   = row_neg ? (cy_ext - mag_ext) : (cy_ext + mag_ext);
    assign left_next  = cx_ext - half_ext;
    assign right_next = cx_ext + half_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= hold_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_row_reg   <= row_next;
            m_left_reg  <= left_next;
            m_right_reg <= right_next;
            m_kind_reg  <= hold_kind_reg;
            m_last_reg  <= (hold_kind_reg == SPAN_NEG_J);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_span_row   = m_row_reg;
    assign m_span_left  = m_left_reg;
    assign m_span_right = m_right_reg;
    assign m_span_kind  = m_kind_reg;
    assign m_last_span  = m_last_reg;

endmodule

FILE: sv/filled_circle_span_generator.sv
// ----------------------------------------------------------------------------
// Filled circle span generator
// Scanline fill of a circle: one step index in, four horizontal spans out.
// ----------------------------------------------------------------------------
// Each accepted step i with 1414*i <= 1000*radius yields j = floor(sqrt(r*r - i*i))
// and four spans, in order: row +j half i, row +i half j, row -i half j,
// row -j half i, each from centre_x-half to centre_x+half, the fourth marked
// last. Steps beyond the limit produce nothing.
// The input side accepts a step every cycle until the pipeline backs up; the
// single result port delivers one span per cycle while m_ready is high, so it
// sets the sustained rate of passing steps. From step accept to the first span a
// step passes the limit/square stage, the subtract stage, COORD_WIDTH-1
// square-root stages (one root bit each), the span hold register and the output
// register. Write configuration only while idle.
// ----------------------------------------------------------------------------
module filled_circle_span_generator
    import fcsg_pkg::*;
#(
    parameter int COORD_WIDTH = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,

    // step request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [STEP_W-1:0]           s_step_index,

    // span result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [COORD_WIDTH:0] m_span_row,
    output logic signed [COORD_WIDTH:0] m_span_left,
    output logic signed [COORD_WIDTH:0] m_span_right,
    output logic [1:0]                  m_span_kind,
    output logic                        m_last_span
);

    localparam int RW = COORD_WIDTH - 1;
    localparam int NW = 2 * RW;

    // configuration registers
    logic signed [COORD_WIDTH-1:0] centre_x_reg;
    logic signed [COORD_WIDTH-1:0] centre_y_reg;
    logic [RW-1:0]                 radius_reg;

    reg_idx_t                      reg_sel;
    logic                          cfg_wr;

    // front end to square root
    logic              fe_valid;
    logic              fe_ready;
    logic [STEP_W-1:0] fe_step;
    logic [NW-1:0]     fe_rem;

    // square root to span sequencer
    logic              sq_valid;
    logic              sq_ready;
    logic [STEP_W-1:0] sq_step;
    logic [RW-1:0]     sq_root;

    span_kind_t        span_kind;

    // --- configuration port: zero wait states, word-addressed registers ---
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            radius_reg   <= '0;
        end else if (cfg_wr) begin
            // keep the low bits of each write, drop unknown addresses
            case (reg_sel)
                REG_CENTRE_X: centre_x_reg <= pwdata[COORD_WIDTH-1:0];
                REG_CENTRE_Y: centre_y_reg <= pwdata[COORD_WIDTH-1:0];
                REG_RADIUS:   radius_reg   <= pwdata[RW-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_CENTRE_X: prdata = APB_DATA_W'(centre_x_reg);
            REG_CENTRE_Y: prdata = APB_DATA_W'(centre_y_reg);
            REG_RADIUS:   prdata = APB_DATA_W'(radius_reg);
            default:      prdata = '0;
        endcase
    end

    // --- limit test, squares and radicand ---
    fcsg_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .radius    (radius_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_step   (s_step_index),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_step  (fe_step),
        .out_rem   (fe_rem)
    );

    // --- one root bit per stage ---
    fcsg_sqrt #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_step   (fe_step),
        .in_rem    (fe_rem),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_step  (sq_step),
        .out_root  (sq_root)
    );

    // --- hold the step, emit four spans through the output register ---
    fcsg_span #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_span (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .centre_x     (centre_x_reg),
        .centre_y     (centre_y_reg),
        .in_valid     (sq_valid),
        .in_ready     (sq_ready),
        .in_step      (sq_step),
        .in_root      (sq_root),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_span_row   (m_span_row),
        .m_span_left  (m_span_left),
        .m_span_right (m_span_right),
        .m_span_kind  (span_kind),
        .m_last_span  (m_last_span)
    );

    assign m_span_kind = span_kind;

`ifndef SYNTHESIS
    // last flag marks exactly the fourth span
    a_last_on_fourth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_span == (span_kind == SPAN_NEG_J)))
        else $error("last_span does not match the fourth span");

    // the four spans of a step go out back to back while the consumer takes them
    a_spans_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (span_kind != SPAN_NEG_J)) |=> m_valid)
        else $error("gap inside the spans of one step");

    // a span following an accepted non-final span advances its kind by one
    a_kind_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (span_kind != SPAN_NEG_J))
            |=> (span_kind == span_kind_t'($past(span_kind) + 2'd1)))
        else $error("span kind out of order");
`endif

endmodule
